/* hdl/cid_fsk_bit_modulator_core_assert.svh */
// Assertion macros for the FSK modulator RTL, used by cfsk_back.
// Expects clk and arst_n in the scope of each use.
`ifndef CID_FSK_BIT_MODULATOR_CORE_ASSERT_SVH
`define CID_FSK_BIT_MODULATOR_CORE_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define CFSK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another in the next cycle.
`define CFSK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/cfsk_pkg.sv */
// Shared types, constants and the sine table of the FSK bit modulator.
// No dependencies; every other file but the assertion macro header imports it.
package cfsk_pkg;

	localparam int PHASE_FRACTION_BITS_DEF = 16;
	localparam int STEP_W                  = 23;
	localparam int SAMPLE_W                = 14;
	localparam int ROM_AW                  = 8;
	localparam int ROM_DW                  = 16;
	localparam int CFG_IDX_W               = 2;
	localparam int QUEUE_DEPTH             = 2;
	localparam int RUN_SHORT               = 6;
	localparam int RUN_LONG                = 7;
	localparam int RUN_CNT_W               = 3;

	localparam logic [STEP_W-1:0] MARK_STEP_RESET  = 23'd2726298;
	localparam logic [STEP_W-1:0] SPACE_STEP_RESET = 23'd4404019;

	// floor(a / 5) == (a * 52429) >> 18 for every 16-bit unsigned a
	localparam int               DIV5_SHIFT = 18;
	localparam logic [16:0]      DIV5_MUL   = 17'd52429;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARK_STEP  = 2'd0,
		REG_SPACE_STEP = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic bit_value;
		logic long_run;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [ROM_DW-1:0] SINE_ROM [256] = '{
		16'h0324,16'h0647,16'h096A,16'h0C8B,16'h0FAB,16'h12C7,16'h15E1,16'h18F8,
		16'h1C0B,16'h1F19,16'h2223,16'h2527,16'h2826,16'h2B1E,16'h2E10,16'h30FB,
		16'h33DE,16'h36B9,16'h398C,16'h3C56,16'h3F16,16'h41CD,16'h447A,16'h471C,
		16'h49B3,16'h4C3F,16'h4EBF,16'h5133,16'h539A,16'h55F4,16'h5842,16'h5A81,
		16'h5CB3,16'h5ED6,16'h60EB,16'h62F1,16'h64E7,16'h66CE,16'h68A5,16'h6A6C,
		16'h6C23,16'h6DC9,16'h6F5E,16'h70E1,16'h7254,16'h73B5,16'h7503,16'h7640,
		16'h776B,16'h7883,16'h7989,16'h7A7C,16'h7B5C,16'h7C29,16'h7CE2,16'h7D89,
		16'h7E1C,16'h7E9C,16'h7F08,16'h7F61,16'h7FA6,16'h7FD7,16'h7FF5,16'h7FFE,
		16'h7FF5,16'h7FD7,16'h7FA6,16'h7F61,16'h7F08,16'h7E9C,16'h7E1C,16'h7D89,
		16'h7CE2,16'h7C29,16'h7B5C,16'h7A7C,16'h7989,16'h7883,16'h776B,16'h7640,
		16'h7503,16'h73B5,16'h7254,16'h70E1,16'h6F5E,16'h6DC9,16'h6C23,16'h6A6C,
		16'h68A5,16'h66CE,16'h64E7,16'h62F1,16'h60EB,16'h5ED6,16'h5CB3,16'h5A81,
		16'h5842,16'h55F5,16'h539A,16'h5133,16'h4EBF,16'h4C3F,16'h49B3,16'h471C,
		16'h447A,16'h41CD,16'h3F16,16'h3C56,16'h398C,16'h36B9,16'h33DE,16'h30FB,
		16'h2E10,16'h2B1E,16'h2826,16'h2527,16'h2223,16'h1F19,16'h1C0B,16'h18F8,
		16'h15E1,16'h12C7,16'h0FAB,16'h0C8B,16'h096A,16'h0647,16'h0324,16'h0000,
		16'hFCDC,16'hF9B9,16'hF696,16'hF375,16'hF056,16'hED39,16'hEA1F,16'hE708,
		16'hE3F5,16'hE0E7,16'hDDDD,16'hDAD9,16'hD7DA,16'hD4E2,16'hD1F0,16'hCF05,
		16'hCC22,16'hC947,16'hC674,16'hC3AA,16'hC0EA,16'hBE33,16'hBB86,16'hB8E4,
		16'hB64D,16'hB3C1,16'hB141,16'hAECD,16'hAC66,16'hAA0C,16'hA7BE,16'hA57F,
		16'hA34D,16'hA12A,16'h9F15,16'h9D0F,16'h9B19,16'h9932,16'h975B,16'h9594,
		16'h93DD,16'h9237,16'h90A2,16'h8F1F,16'h8DAC,16'h8C4C,16'h8AFD,16'h89C0,
		16'h8895,16'h877D,16'h8677,16'h8584,16'h84A4,16'h83D8,16'h831E,16'h8277,
		16'h81E4,16'h8164,16'h80F8,16'h809F,16'h805A,16'h8029,16'h800B,16'h8002,
		16'h800B,16'h8029,16'h805A,16'h809F,16'h80F8,16'h8164,16'h81E4,16'h8277,
		16'h831E,16'h83D7,16'h84A4,16'h8584,16'h8677,16'h877D,16'h8895,16'h89C0,
		16'h8AFD,16'h8C4B,16'h8DAC,16'h8F1F,16'h90A2,16'h9237,16'h93DD,16'h9594,
		16'h975B,16'h9932,16'h9B19,16'h9D0F,16'h9F15,16'hA12A,16'hA34D,16'hA57F,
		16'hA7BE,16'hAA0B,16'hAC66,16'hAECD,16'hB141,16'hB3C1,16'hB64D,16'hB8E4,
		16'hBB86,16'hBE33,16'hC0EA,16'hC3AA,16'hC674,16'hC947,16'hCC22,16'hCF05,
		16'hD1F0,16'hD4E1,16'hD7DA,16'hDAD9,16'hDDDD,16'hE0E7,16'hE3F5,16'hE708,
		16'hEA1E,16'hED38,16'hF055,16'hF375,16'hF696,16'hF9B9,16'hFCDC,16'h0000
	};

endpackage

/* hdl/cfsk_if.sv */
// Handshake channels of the FSK modulator: bit input, sample output, register writes.
// Depends on cfsk_pkg for payload widths.
interface cfsk_bit_if;
	logic valid;
	logic ready;
	logic bit_value;
	modport source (output valid, output bit_value, input ready);
	modport sink   (input valid, input bit_value, output ready);
endinterface

interface cfsk_smp_if;
	import cfsk_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;
	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface cfsk_cfg_if;
	import cfsk_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [STEP_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/cfsk_front.sv */
// Front end: accepts bit words and tags each with its run length from the 6,7,7,7 pattern.
// Depends on cfsk_pkg and cfsk_if.
module cfsk_front (
	input  logic              clk,
	input  logic              arst_n,
	cfsk_bit_if.sink          bits,
	input  cfsk_pkg::q_stat_t qstat,
	output logic              push,
	output cfsk_pkg::item_t   push_item
);
	import cfsk_pkg::*;

	logic [1:0] pattern_pos_q;

	assign bits.ready          = !qstat.full;
	assign push                = bits.valid && !qstat.full;
	assign push_item.bit_value = bits.bit_value;
	// position zero of the pattern gets the short run
	assign push_item.long_run  = (pattern_pos_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_pos_q <= 2'd0;
		end else if (push) begin
			pattern_pos_q <= pattern_pos_q + 2'd1;
		end
	end

endmodule

/* hdl/cfsk_queue.sv */
// Short queue of tagged bit words between front and back end.
// Depends on cfsk_pkg.
module cfsk_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cfsk_pkg::item_t   push_item,
	input  logic              pop,
	output cfsk_pkg::item_t   head,
	output cfsk_pkg::q_stat_t qstat
);
	import cfsk_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_ptr_q];
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hdl/cfsk_back.sv */
// Back end: steps the phase once per sample, reads the sine table, divides by five.
// Depends on cfsk_pkg, cfsk_if and the assertion macro header.
`include "cid_fsk_bit_modulator_core_assert.svh"

module cfsk_back #(
	parameter int PHASE_FRACTION_BITS = cfsk_pkg::PHASE_FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfsk_pkg::item_t             head,
	input  cfsk_pkg::q_stat_t           qstat,
	output logic                        pop,
	input  logic [cfsk_pkg::STEP_W-1:0] mark_step,
	input  logic [cfsk_pkg::STEP_W-1:0] space_step,
	cfsk_smp_if.source                  smp
);
	import cfsk_pkg::*;

	localparam int ACC_W = 8 + PHASE_FRACTION_BITS;
	localparam int SUM_W = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 1;
	localparam logic [SUM_W-1:0] LIMIT = SUM_W'(255) << PHASE_FRACTION_BITS;

	logic                       en;
	logic                       issue;
	logic                       last;
	logic [RUN_CNT_W-1:0]       cnt_q;
	logic [STEP_W-1:0]          step;
	logic [SUM_W-1:0]           sum;
	logic [SUM_W-1:0]           reduced;
	logic [ACC_W-1:0]           phase_acc_q;
	logic                       valid_s1;
	logic                       last_s1;
	logic [ROM_DW-1:0]          rom_s2;
	logic                       valid_s2;
	logic                       last_s2;
	logic                       neg;
	logic [ROM_DW-1:0]          mag;
	logic [ROM_DW+16:0]         prod;
	logic [SAMPLE_W-1:0]        quot;
	logic signed [SAMPLE_W-1:0] sample_s3;
	logic                       last_s3;
	logic                       valid_s3;

	// whole pipeline moves when the output register is free or being taken
	assign en    = !valid_s3 || smp.ready;
	assign issue = en && !qstat.empty;
	assign last  = head.long_run ? (cnt_q == RUN_CNT_W'(RUN_LONG - 1))
	                             : (cnt_q == RUN_CNT_W'(RUN_SHORT - 1));
	assign pop   = issue && last;

	assign step    = head.bit_value ? mark_step : space_step;
	assign sum     = SUM_W'(phase_acc_q) + SUM_W'(step);
	assign reduced = (sum > LIMIT) ? sum - LIMIT : sum;

	// truncate toward zero: divide the magnitude, then restore the sign
	assign neg  = rom_s2[ROM_DW-1];
	assign mag  = neg ? (~rom_s2 + 1'b1) : rom_s2;
	assign prod = mag * DIV5_MUL;
	assign quot = prod[DIV5_SHIFT +: SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			phase_acc_q <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
		end else if (en) begin
			if (issue) begin
				cnt_q       <= last ? '0 : cnt_q + 1'b1;
				phase_acc_q <= reduced[ACC_W-1:0];
			end
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1   <= last;
			rom_s2    <= SINE_ROM[phase_acc_q[PHASE_FRACTION_BITS +: ROM_AW]];
			last_s2   <= last_s1;
			sample_s3 <= neg ? (~quot + 1'b1) : quot;
			last_s3   <= last_s2;
		end
	end

	assign smp.valid       = valid_s3;
	assign smp.sample      = sample_s3;
	assign smp.last_sample = last_s3;

	`CFSK_ASSERT(a_cnt_range, cnt_q <= RUN_CNT_W'(RUN_LONG - 1), "sample count out of range")
	`CFSK_ASSERT(a_run_head_held, (cnt_q == '0) || !qstat.empty, "head word lost mid-run")
	`CFSK_ASSERT_NEXT(a_stall_phase, !en, $stable(phase_acc_q), "phase moved during stall")
	`CFSK_ASSERT_NEXT(a_run_restart, pop, cnt_q == '0, "count not cleared after run")

endmodule

/* hdl/cid_fsk_bit_modulator_core.sv */
// Top level of the continuous-phase FSK bit modulator: step registers and wiring.
// Depends on cfsk_pkg, cfsk_if, cfsk_front, cfsk_queue and cfsk_back.
//
// Usage:
//   bits    - one word per bit to send (bit_value 1 mark, 0 space).
//   samples - one word per output sample: sample (signed 14 bit) and
//             last_sample, high on the final sample of a bit's run.
//   cfg     - register writes: index 0 mark step, index 1 space step,
//             other indexes are dropped. ready is always high; write only
//             while no bit is in flight.
// A bit produces 6 or 7 samples following the pattern 6,7,7,7 from reset,
// so a steady stream gives 27 samples per 4 bits, one sample per cycle while
// the receiver takes them. After a word is accepted, the first sample of its
// bit passes the queue and the pipeline registers s1, s2 and s3. The rate
// is set by the single phase accumulator, which advances once per sample.
// A two-word queue lets bits be accepted while samples are still being
// produced or wait on a stalled receiver; a stalled receiver freezes the
// sample pipeline and the queue fills, then bits.ready drops.
// Reset clears the phase to zero, restarts the run pattern at six and
// loads the V.23 steps (41.6 and 67.2 in Q7.16).
module cid_fsk_bit_modulator_core #(
	parameter int PHASE_FRACTION_BITS = cfsk_pkg::PHASE_FRACTION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cfsk_bit_if.sink   bits,
	cfsk_smp_if.source samples,
	cfsk_cfg_if.sink   cfg
);
	import cfsk_pkg::*;

	logic [STEP_W-1:0] mark_step_q;
	logic [STEP_W-1:0] space_step_q;
	logic              push;
	logic              pop;
	item_t             push_item;
	item_t             head;
	q_stat_t           qstat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_step_q  <= MARK_STEP_RESET;
			space_step_q <= SPACE_STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MARK_STEP:  mark_step_q  <= cfg.data;
				REG_SPACE_STEP: space_step_q <= cfg.data;
				default: ;
			endcase
		end
	end

	cfsk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bits      (bits),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	cfsk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	cfsk_back #(
		.PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.mark_step  (mark_step_q),
		.space_step (space_step_q),
		.smp        (samples)
	);

endmodule
